// ===== sv/bdc_pkg.sv =====
`default_nettype none
package bdc_pkg;

  localparam int DictEntries = 128;
  localparam int CharW       = 7;
  localparam int ByteW       = 8;
  localparam int PairW       = 2 * CharW;
  localparam int TdataInW    = 32;
  localparam int ApbAddrW    = 3;
  localparam int ApbDataW    = 32;

  localparam int EntryLsb  = 0;
  localparam int FirstLsb  = EntryLsb + CharW;
  localparam int SecondLsb = FirstLsb + CharW;
  localparam int ByteLsb   = SecondLsb + CharW;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic REG_DIRECTION = 1'b0;

  localparam logic [ByteW-1:0] TOKEN_FLAG = 8'h80;

  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] count;
    out_word_t  w0;
    out_word_t  w1;
  } push_t;

  typedef struct packed {
    logic             hit;
    logic [CharW-1:0] idx;
  } match_t;

endpackage
`default_nettype wire

// ===== sv/bdc_ram.sv =====
`default_nettype none
module bdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/bdc_dict.sv =====
`default_nettype none
module bdc_dict #(
  parameter int DICT_ENTRIES = bdc_pkg::DictEntries
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            we_i,
  input  wire logic [$clog2(DICT_ENTRIES)-1:0] waddr_i,
  input  wire logic [bdc_pkg::CharW-1:0]       first_i,
  input  wire logic [bdc_pkg::CharW-1:0]       second_i,
  input  wire logic [bdc_pkg::ByteW-1:0]       char_a_i,
  input  wire logic [bdc_pkg::ByteW-1:0]       char_b_i,
  output      bdc_pkg::match_t                 match_o,
  input  wire logic [$clog2(DICT_ENTRIES)-1:0] dec_addr_i,
  output      logic                            dec_valid_o
);
  import bdc_pkg::*;

  logic [DICT_ENTRIES-1:0] valid_q;
  logic [CharW-1:0]        first_q  [DICT_ENTRIES];
  logic [CharW-1:0]        second_q [DICT_ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      first_q[waddr_i]  <= first_i;
      second_q[waddr_i] <= second_i;
    end
  end

  // The last matching cell in index order wins, so the highest index is reported.
  always_comb begin
    match_o = '0;
    if (!char_a_i[ByteW-1] && !char_b_i[ByteW-1]) begin
      for (int i = 0; i < DICT_ENTRIES; i++) begin
        if (valid_q[i] && first_q[i] == char_a_i[CharW-1:0] &&
            second_q[i] == char_b_i[CharW-1:0]) begin
          match_o.hit = 1'b1;
          match_o.idx = CharW'(i);
        end
      end
    end
  end

  assign dec_valid_o = valid_q[dec_addr_i];

endmodule
`default_nettype wire

// ===== sv/bdc_outbuf.sv =====
`default_nettype none
module bdc_outbuf (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_en_i,
  input  wire bdc_pkg::push_t            push_i,
  output      logic                      free_o,
  output      logic                      m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output      logic [bdc_pkg::ByteW-1:0] m_axis_tdata,
  output      logic                      m_axis_tlast
);
  import bdc_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  out_word_t  slot0_q, slot0_d;
  out_word_t  slot1_q, slot1_d;
  logic       pop;

  assign pop    = (cnt_q != PUSH_NONE) && m_axis_tready;
  assign free_o = (cnt_q == PUSH_NONE) || (cnt_q == PUSH_ONE && m_axis_tready);

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (push_en_i) begin
      cnt_d   = push_i.count;
      slot0_d = push_i.w0;
      slot1_d = push_i.w1;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= PUSH_NONE;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign m_axis_tvalid = (cnt_q != PUSH_NONE);
  assign m_axis_tdata  = slot0_q.data;
  assign m_axis_tlast  = slot0_q.last;

endmodule
`default_nettype wire

// ===== sv/bigram_dictionary_codec.sv =====
// A result word is registered in stage one and in the output buffer before it is offered.
// Throughput: one input word per cycle while the output is ready; a word that gives two
// results fills both slots of the two-entry output buffer and stalls the next input word.
// Reset is asynchronous and active low; it clears all dictionary valid bits, the
// pending character and the direction register at once, with no clearing pass.
`default_nettype none
module bigram_dictionary_codec #(
  parameter int DICT_ENTRIES = bdc_pkg::DictEntries
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  // entry_index[6:0], pair_first[13:7], pair_second[20:14], data_byte[28:21]
  input  wire logic [bdc_pkg::TdataInW-1:0] s_axis_tdata,
  // command[0]
  input  wire logic                         s_axis_tuser,
  input  wire logic                         s_axis_tlast,
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // out_byte[7:0]
  output      logic [bdc_pkg::ByteW-1:0]    m_axis_tdata,
  output      logic                         m_axis_tlast,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bdc_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [bdc_pkg::ApbDataW-1:0] pwdata,
  output      logic [bdc_pkg::ApbDataW-1:0] prdata,
  output      logic                         pready
);
  import bdc_pkg::*;

  localparam int AW = $clog2(DICT_ENTRIES);

  logic             dir_q;
  logic             s1_v_q, s1_v_d;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_last_q;
  logic [ByteW-1:0] pend_char_q, pend_char_d;
  logic             pend_v_q, pend_v_d;

  logic             accept, advance, free;
  logic             load_ok;
  logic [CharW-1:0] in_entry, in_first, in_second;
  logic [ByteW-1:0] in_byte;
  logic [PairW-1:0] ram_rdata;
  match_t           match;
  logic             dec_valid, dec_ok;
  push_t            push;

  assign in_entry  = s_axis_tdata[EntryLsb +: CharW];
  assign in_first  = s_axis_tdata[FirstLsb +: CharW];
  assign in_second = s_axis_tdata[SecondLsb +: CharW];
  assign in_byte   = s_axis_tdata[ByteLsb +: ByteW];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DIRECTION) ? {{(ApbDataW-1){1'b0}}, dir_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DIR_ENCODE;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DIRECTION) begin
      dir_q <= pwdata[0];
    end
  end

  assign s_axis_tready = !s1_v_q || free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign advance       = s1_v_q && free;
  assign load_ok       = accept && (s_axis_tuser == CMD_LOAD) &&
                         ({1'b0, in_entry} < 8'(DICT_ENTRIES));

  bdc_ram #(
    .WIDTH(PairW),
    .DEPTH(DICT_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (load_ok),
    .waddr_i(in_entry[AW-1:0]),
    .wdata_i({in_first, in_second}),
    .re_i   (accept),
    .raddr_i(in_byte[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  bdc_dict #(
    .DICT_ENTRIES(DICT_ENTRIES)
  ) u_dict (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (load_ok),
    .waddr_i    (in_entry[AW-1:0]),
    .first_i    (in_first),
    .second_i   (in_second),
    .char_a_i   (pend_char_q),
    .char_b_i   (s1_byte_q),
    .match_o    (match),
    .dec_addr_i (s1_byte_q[AW-1:0]),
    .dec_valid_o(dec_valid)
  );

  assign dec_ok = dec_valid && ({1'b0, s1_byte_q[CharW-1:0]} < 8'(DICT_ENTRIES));

  always_comb begin
    s1_v_d = s1_v_q;
    if (accept) begin
      s1_v_d = (s_axis_tuser == CMD_DATA);
    end else if (advance) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= in_byte;
      s1_last_q <= s_axis_tlast;
    end
  end

  always_comb begin
    push        = '0;
    pend_char_d = pend_char_q;
    pend_v_d    = pend_v_q;
    if (dir_q == DIR_DECODE) begin
      if (s1_byte_q[ByteW-1]) begin
        push.count = PUSH_TWO;
        if (dec_ok) begin
          push.w0.data = {1'b0, ram_rdata[PairW-1:CharW]};
          push.w1.data = {1'b0, ram_rdata[CharW-1:0]};
        end
        push.w1.last = s1_last_q;
      end else begin
        push.count   = PUSH_ONE;
        push.w0.data = s1_byte_q;
        push.w0.last = s1_last_q;
      end
    end else if (!pend_v_q) begin
      if (s1_last_q) begin
        push.count   = PUSH_ONE;
        push.w0.data = s1_byte_q;
        push.w0.last = 1'b1;
      end else begin
        pend_char_d = s1_byte_q;
        pend_v_d    = 1'b1;
      end
    end else if (match.hit) begin
      push.count   = PUSH_ONE;
      push.w0.data = TOKEN_FLAG | {1'b0, match.idx};
      push.w0.last = s1_last_q;
      pend_char_d  = '0;
      pend_v_d     = 1'b0;
    end else begin
      push.w0.data = pend_char_q;
      if (s1_last_q) begin
        push.count   = PUSH_TWO;
        push.w1.data = s1_byte_q;
        push.w1.last = 1'b1;
        pend_char_d  = '0;
        pend_v_d     = 1'b0;
      end else begin
        push.count  = PUSH_ONE;
        pend_char_d = s1_byte_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_char_q <= '0;
      pend_v_q    <= 1'b0;
    end else if (advance) begin
      pend_char_q <= pend_char_d;
      pend_v_q    <= pend_v_d;
    end
  end

  bdc_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_en_i    (advance),
    .push_i       (push),
    .free_o       (free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
`default_nettype wire
